[rtl/sfm_pkg.sv]
// Package with the shared constants and codes of the substring first-match block.
`default_nettype none

package sfm_pkg;

  // Default capacity of the pattern store and of the text window, in bytes.
  localparam int MAX_LEN_DEF = 64;

  // Field widths on the stream ports.
  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int STAT_W = 2;
  localparam int POS_W  = 6;

  // Command codes carried with each input transfer.
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_PAT    = 2'd1,
    CMD_TEXT   = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_t;

  // Status codes returned by a finish command.
  typedef enum logic [STAT_W-1:0] {
    ST_FOUND    = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

endpackage

`default_nettype wire

[rtl/substring_first_match_top.sv]
// Top level of the substring first-match block: input stage, window compare and result register.
`default_nettype none

// Substring first match. Load a pattern with append-pattern commands, then stream
// text with append-text commands; each text byte is compared in parallel against
// the whole pattern over the bytes of text that end at it, and the first match is
// latched. A finish command returns one result transfer (status on out_tuser, match
// position on out_tdata) and clears the text while keeping the pattern. Clear-all
// drops pattern, text and match. Bytes beyond MAX_LEN are ignored, and pattern bytes
// that arrive after text loading has begun are ignored. The block takes one input
// transfer per cycle unless a finish waits for the result register. A finish
// passes the input register, then loads the result register. While a result
// waits on the result channel, a following finish holds the input stage and the
// input channel stalls until the waiting result is taken. The single compare
// stage, a MAX_LEN-wide bank of byte comparators between the input register and the
// state registers, sets that rate. No clearing pass is needed after reset.
module substring_first_match_top
  import sfm_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  // Input channel
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire  [7:0] in_tdata,   // [7:0] character
  input  wire  [1:0] in_tuser,   // [1:0] command
  // Result channel
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [7:0] out_tdata,  // [5:0] position, [7:6] zero
  output logic [1:0] out_tuser   // [1:0] status
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);

  // Input register
  logic              s1_valid_r;
  cmd_t              s1_cmd_r;
  logic [CHAR_W-1:0] s1_char_r;

  // Block state
  logic [CHAR_W-1:0] pat_r [MAX_LEN];   // pat_r[0] is the last pattern byte
  logic [CHAR_W-1:0] win_r [MAX_LEN];   // win_r[0] is the newest text byte
  logic [CHAR_W-1:0] win_nxt [MAX_LEN];
  logic [CNT_W-1:0]  pat_cnt_r;
  logic [CNT_W-1:0]  txt_cnt_r;
  logic              seen_r;
  logic [CNT_W-1:0]  idx_r;

  // Result register
  logic              out_valid_r;
  status_t           out_status_r;
  logic [POS_W-1:0]  out_pos_r;

  logic              adv;
  logic              in_acc;
  logic              win_hit;
  logic [CNT_W:0]    txt_end;
  logic              pat_room;
  logic              txt_room;
  logic              do_pat;
  logic              do_txt;
  logic              hit_new;
  status_t           status_nxt;
  logic [POS_W+CNT_W-1:0] pos_ext;

  // The stage advances unless a finish must wait for the result register.
  assign adv = s1_valid_r &&
               ((s1_cmd_r != CMD_FINISH) || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  // Input register load.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r  <= cmd_t'(in_tuser[CMD_W-1:0]);
      s1_char_r <= in_tdata[CHAR_W-1:0];
    end
  end

  // Text window after the incoming byte is shifted in.
  always_comb begin
    win_nxt[0] = s1_char_r;
    for (int j = 1; j < MAX_LEN; j++) begin
      win_nxt[j] = win_r[j-1];
    end
  end

  // Parallel compare of every pattern byte against the window ending at the new byte.
  always_comb begin
    win_hit = 1'b1;
    for (int j = 0; j < MAX_LEN; j++) begin
      if ((CNT_W'(j) < pat_cnt_r) && (win_nxt[j] != pat_r[j])) begin
        win_hit = 1'b0;
      end
    end
  end

  assign pat_room = pat_cnt_r < CNT_W'(MAX_LEN);
  assign txt_room = txt_cnt_r < CNT_W'(MAX_LEN);
  assign txt_end  = {1'b0, txt_cnt_r} + 1'b1;
  assign do_pat   = adv && (s1_cmd_r == CMD_PAT) && (txt_cnt_r == '0) && pat_room;
  assign do_txt   = adv && (s1_cmd_r == CMD_TEXT) && txt_room;
  assign hit_new  = !seen_r && (pat_cnt_r != '0) &&
                    (txt_end >= {1'b0, pat_cnt_r}) && win_hit;

  // Pattern and text shift registers.
  always_ff @(posedge clk) begin
    if (do_pat) begin
      pat_r[0] <= s1_char_r;
      for (int j = 1; j < MAX_LEN; j++) begin
        pat_r[j] <= pat_r[j-1];
      end
    end
    if (do_txt) begin
      win_r <= win_nxt;
    end
  end

  // Counters and the latched match.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_cnt_r <= '0;
      txt_cnt_r <= '0;
      seen_r    <= 1'b0;
      idx_r     <= '0;
    end else if (adv) begin
      case (s1_cmd_r)
        CMD_CLEAR: begin
          pat_cnt_r <= '0;
          txt_cnt_r <= '0;
          seen_r    <= 1'b0;
          idx_r     <= '0;
        end
        CMD_PAT: begin
          if (do_pat) begin
            pat_cnt_r <= pat_cnt_r + 1'b1;
          end
        end
        CMD_TEXT: begin
          if (do_txt) begin
            txt_cnt_r <= txt_end[CNT_W-1:0];
            if (hit_new) begin
              seen_r <= 1'b1;
              idx_r  <= CNT_W'(txt_end - {1'b0, pat_cnt_r});
            end
          end
        end
        CMD_FINISH: begin
          txt_cnt_r <= '0;
          seen_r    <= 1'b0;
          idx_r     <= '0;
        end
        default: begin
          txt_cnt_r <= txt_cnt_r;
        end
      endcase
    end
  end

  // Status of a finish command.
  always_comb begin
    if (pat_cnt_r == '0) begin
      status_nxt = ST_EMPTY;
    end else if ((pat_cnt_r > txt_cnt_r) || !seen_r) begin
      status_nxt = ST_NOTFOUND;
    end else begin
      status_nxt = ST_FOUND;
    end
  end

  // The position is the low bits of the match index.
  assign pos_ext = {{POS_W{1'b0}}, idx_r};

  // Result register: holds a result until the result channel takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && (s1_cmd_r == CMD_FINISH)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && (s1_cmd_r == CMD_FINISH)) begin
      out_status_r <= status_nxt;
      out_pos_r    <= (status_nxt == ST_FOUND) ? pos_ext[POS_W-1:0] : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(8-POS_W){1'b0}}, out_pos_r};
  assign out_tuser  = out_status_r;

  // A latched match always lies inside the loaded text.
  a_seen_in_text: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r |-> ((pat_cnt_r != '0) &&
                ({1'b0, idx_r} + {1'b0, pat_cnt_r} <= {1'b0, txt_cnt_r})))
    else $error("latched match lies outside the loaded text");

  // The pattern only grows while no text is loaded.
  a_pat_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (pat_cnt_r > $past(pat_cnt_r)) |-> ($past(txt_cnt_r) == '0))
    else $error("pattern grew while text was loaded");

  // The text count never passes the window size.
  a_txt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    txt_cnt_r <= CNT_W'(MAX_LEN))
    else $error("text count beyond window size");

  // A result waiting on a stalled channel is never overwritten.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !(adv && (s1_cmd_r == CMD_FINISH)))
    else $error("pending result overwritten");

  // A finish that waits for the result register holds back the input channel.
  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |-> !in_tready)
    else $error("input taken while the stage is stalled");

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the substring first-match block.
`timescale 1ns / 1ps

module testbench;
  import sfm_pkg::*;

  localparam int DEPTH      = MAX_LEN_DEF;
  localparam int ITEM_GOAL  = 1800;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN      = 8;

  // Receiver stall styles.
  localparam int RX_OPEN   = 0;
  localparam int RX_CHOPPY = 1;
  localparam int RX_SLOW   = 2;

  // One expected finish result.
  typedef struct packed {
    status_t    status;
    logic [5:0] position;
  } find_result_t;

  // Tracks pattern, text and the first match, and checks finish results.
  class match_tracker;
    logic [7:0]   pat_bytes[DEPTH];
    logic [7:0]   txt_bytes[DEPTH];
    int           pat_len = 0;
    int           txt_len = 0;
    bit           hit = 0;
    int           hit_at = 0;
    find_result_t pending_finds[$];
    int           errors = 0;

    function void drop_text();
      txt_len = 0;
      hit     = 0;
      hit_at  = 0;
    endfunction

    // Update the state for one accepted input transfer.
    function void take_command(cmd_t cmd, logic [7:0] ch);
      find_result_t res;
      bit           same;
      case (cmd)
        CMD_CLEAR: begin
          pat_len = 0;
          drop_text();
        end
        CMD_PAT: begin
          // The pattern freezes once text has started, and stops at capacity.
          if (txt_len == 0 && pat_len < DEPTH) begin
            pat_bytes[pat_len] = ch;
            pat_len++;
          end
        end
        CMD_TEXT: begin
          if (txt_len < DEPTH) begin
            txt_bytes[txt_len] = ch;
            txt_len++;
            if (!hit && pat_len != 0 && txt_len >= pat_len) begin
              same = 1;
              for (int i = 0; i < pat_len; i++)
                if (txt_bytes[txt_len - pat_len + i] !== pat_bytes[i]) same = 0;
              if (same) begin
                hit    = 1;
                hit_at = txt_len - pat_len;
              end
            end
          end
        end
        default: begin
          res.position = '0;
          if (pat_len == 0) begin
            res.status = ST_EMPTY;
          end else if (pat_len > txt_len || !hit) begin
            res.status = ST_NOTFOUND;
          end else begin
            res.status   = ST_FOUND;
            res.position = hit_at[5:0];
          end
          pending_finds.push_back(res);
          drop_text();
        end
      endcase
    endfunction

    // Compare one accepted result transfer with the oldest expectation.
    function void check_find(logic [1:0] status, logic [7:0] data);
      find_result_t want;
      if (pending_finds.size() == 0) begin
        $error("unexpected result: status %0d position %0d", status, data[5:0]);
        errors++;
        return;
      end
      want = pending_finds.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        errors++;
      end
      if (data[5:0] !== want.position) begin
        $error("position: expected %0d, got %0d", want.position, data[5:0]);
        errors++;
      end
      if (data[7:6] !== 2'b00) begin
        $error("tdata padding: expected 0, got %0d", data[7:6]);
        errors++;
      end
    endfunction

    function int pending();
      return pending_finds.size();
    endfunction
  endclass

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = '0;
  logic [1:0] in_tuser   = '0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;

  match_tracker tracker = new;
  int           items_sent = 0;
  int           burst_left = 0;
  int           idle_cycles = 0;
  int           rx_mode = RX_OPEN;
  int           rx_span = 0;

  substring_first_match_top #(.MAX_LEN(DEPTH)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Send one command; the sender pauses between bursts of random length.
  task automatic send_item(cmd_t cmd, logic [7:0] ch);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= ch;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.take_command(cmd, ch);
    items_sent++;
    burst_left--;
  endtask

  // One search: optional clear, a pattern, text with a planted copy, then finish.
  task automatic run_search();
    logic [7:0] sym_a;
    logic [7:0] sym_b;
    logic [7:0] key[$];
    logic [7:0] ch;
    int         key_len;
    int         text_len;
    int         plant_at;
    bit         wild;
    sym_a = 8'($urandom_range(0, 255));
    sym_b = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 255))
                                        : sym_a ^ (8'h01 << $urandom_range(0, 7));
    wild  = ($urandom_range(0, 5) == 0);
    if ($urandom_range(0, 3) != 0) send_item(CMD_CLEAR, 8'($urandom_range(0, 255)));

    // Mostly short patterns; now and then a long one near or past the store's capacity.
    key_len = ($urandom_range(0, 19) == 0) ? $urandom_range(58, 66) : $urandom_range(0, 6);
    for (int i = 0; i < key_len; i++) begin
      ch = ($urandom_range(0, 1) == 1) ? sym_a : sym_b;
      key.push_back(ch);
      send_item(CMD_PAT, ch);
    end

    // Mostly short texts; now and then a long one near or past capacity.
    text_len = ($urandom_range(0, 11) == 0) ? $urandom_range(56, 70) : $urandom_range(0, 24);
    plant_at = -1;
    if (key_len != 0 && text_len >= key_len && $urandom_range(0, 3) != 0)
      plant_at = $urandom_range(0, text_len - key_len);
    for (int t = 0; t < text_len; t++) begin
      if (plant_at >= 0 && t >= plant_at && t < plant_at + key_len)
        ch = key[t - plant_at];
      else if (wild)
        ch = 8'($urandom_range(0, 255));
      else
        ch = ($urandom_range(0, 1) == 1) ? sym_a : sym_b;
      send_item(CMD_TEXT, ch);
      // Late pattern bytes and stray commands as noise.
      if ($urandom_range(0, 39) == 0) send_item(CMD_PAT, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 149) == 0)
        send_item(cmd_t'(2'($urandom_range(0, 3))), 8'($urandom_range(0, 255)));
    end
    send_item(CMD_FINISH, 8'($urandom_range(0, 255)));
  endtask

  // Receiver picks a new stall style each time its random span runs out.
  always @(posedge clk) begin
    if (rx_span == 0) begin
      rx_mode = $urandom_range(RX_OPEN, RX_SLOW);
      rx_span = $urandom_range(20, 120);
    end
    rx_span = rx_span - 1;
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_CHOPPY: out_tready <= ($urandom_range(0, 1) == 1);
      default:   out_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // Check every accepted result transfer.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_find(out_tuser, out_tdata);
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles = 0;
      else
        idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pattern right after reset.
    send_item(CMD_FINISH, 8'hFF);
    // Extreme bytes; a later match and a late pattern byte are both ignored.
    send_item(CMD_PAT, 8'h00);
    send_item(CMD_PAT, 8'hFF);
    send_item(CMD_TEXT, 8'hFF);
    send_item(CMD_TEXT, 8'h00);
    send_item(CMD_TEXT, 8'hFF);
    send_item(CMD_TEXT, 8'h00);
    send_item(CMD_TEXT, 8'hFF);
    send_item(CMD_PAT, 8'h55);
    send_item(CMD_FINISH, 8'h00);
    // Pattern kept after finish; text shorter than the pattern.
    send_item(CMD_TEXT, 8'h00);
    send_item(CMD_FINISH, 8'hA5);
    // No match at all.
    send_item(CMD_TEXT, 8'hAA);
    send_item(CMD_TEXT, 8'hBB);
    send_item(CMD_TEXT, 8'hCC);
    send_item(CMD_FINISH, 8'h5A);
    // Clear all drops the pattern too.
    send_item(CMD_CLEAR, 8'hFF);
    send_item(CMD_FINISH, 8'h00);
    // Match at index zero.
    send_item(CMD_PAT, 8'h7E);
    send_item(CMD_TEXT, 8'h7E);
    send_item(CMD_FINISH, 8'h81);

    while (items_sent < ITEM_GOAL) run_search();
    in_tvalid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (tracker.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
